/* rtl/emgsd_pkg.sv */
// emgsd_pkg: shared constants, types and pipeline depths for the emg strand density block
// no dependencies; used by the interfaces, the exp unit and the top level
`timescale 1ns / 1ps

package emgsd_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN_POSITION    = 3'd0,
    REG_SPREAD           = 3'd1,
    REG_DECAY_RATE       = 3'd2,
    REG_STRAND_BIAS      = 3'd3,
    REG_FOOTPRINT_OFFSET = 3'd4
  } cfg_reg_t;

  // fixed-point constants
  localparam logic [63:0] R8_Q32  = (64'd2828427125 << 32) / 64'd1000000000;
  localparam logic [63:0] LN2_Q28 = (64'd693147181 << 28) / 64'd1000000000;
  localparam logic [30:0] ONE30   = 31'd1 << 30;
  localparam logic [35:0] EXP_CAP = 36'd1 << 35;

  localparam logic [63:0] C0 = (64'd126551223 << 28) / 64'd100000000;
  localparam logic [63:0] C1 = (64'd100002368 << 28) / 64'd100000000;
  localparam logic [63:0] C2 = (64'd37409196 << 28) / 64'd100000000;
  localparam logic [63:0] C3 = (64'd9678418 << 28) / 64'd100000000;
  localparam logic [63:0] C4 = (64'd18628806 << 28) / 64'd100000000;
  localparam logic [63:0] C5 = (64'd27886807 << 28) / 64'd100000000;
  localparam logic [63:0] C6 = (64'd113520398 << 28) / 64'd100000000;
  localparam logic [63:0] C7 = (64'd148851587 << 28) / 64'd100000000;
  localparam logic [63:0] C8 = (64'd82215223 << 28) / 64'd100000000;
  localparam logic [63:0] C9 = (64'd17087277 << 28) / 64'd100000000;

  // erfc polynomial coefficients, Q28, two's complement
  localparam logic [33:0] POLY [0:9] = '{
    -34'(C0), 34'(C1), 34'(C2), 34'(C3), -34'(C4),
    34'(C5), -34'(C6), 34'(C7), -34'(C8), 34'(C9)
  };

  // pipeline depths
  localparam int WDIV_STG = 40;
  localparam int TDIV_STG = 29;
  localparam int HORN_STG = 18;
  localparam int EXP_LAT  = 45;
  localparam int PIPE_DEPTH = 2 + WDIV_STG + 2 + TDIV_STG + HORN_STG + 1 + EXP_LAT + 3;

  typedef struct packed {
    logic        plus;
    logic        szero;
    logic        dneg;
    logic        sat;
    logic [32:0] dmag;
    logic [50:0] ls;
  } wc_t;

  typedef struct packed {
    logic        plus;
    logic        szero;
    logic        big;
    logic        lsbig;
    logic [52:0] v;
    logic [55:0] whsq;
    logic [48:0] ldh;
    logic [47:0] ldl;
    logic [55:0] lsq;
  } v1_t;

  typedef struct packed {
    logic        plus;
    logic        szero;
    logic        vneg;
    logic        lsbig;
    logic [35:0] u28;
    logic [35:0] m1;
  } tc_t;

  typedef struct packed {
    tc_t         t;
    logic [28:0] tau;
  } hc_t;

  typedef struct packed {
    logic        plus;
    logic        szero;
    logic        vneg;
    logic        lsbig;
    logic [32:0] lt;
  } xc_t;

endpackage

/* rtl/emgsd_if.sv */
// emgsd channel interfaces: configuration writes, read words in, density words out
// depends on emgsd_pkg
`timescale 1ns / 1ps

interface emgsd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [emgsd_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface emgsd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic               strand_plus;
  modport source (output valid, position, strand_plus, input ready);
  modport sink (input valid, position, strand_plus, output ready);
endinterface

interface emgsd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] density;
  logic        forced_zero;
  modport source (output valid, density, forced_zero, input ready);
  modport sink (input valid, density, forced_zero, output ready);
endinterface

/* rtl/emg_strand_density.sv */
// emg_strand_density: strand-weighted exponentially modified gaussian density
// depends on emgsd_pkg, emgsd_if (channel interfaces) and emgsd_exp
`timescale 1ns / 1ps

// One read word in, one density word out, in order, one word per clock sustained.
// Along the pipeline a 40-stage restoring divider forms
// d/sigma, a 29-stage divider forms tau, the erfc polynomial takes 18 stages, and two
// 45-stage exp units run side by side. The whole pipeline advances together; it holds
// only while a finished word sits in the output register and result.ready is low.
// Configuration registers are read straight by many stages, so write them only while
// no read is in flight. Writes to an unknown index are dropped; cfg.ready is always high.
module emg_strand_density (
  input  logic              clk,
  input  logic              rst,
  emgsd_cfg_if.sink         cfg,
  emgsd_in_if.sink          reads,
  emgsd_out_if.source       result
);

  localparam int LAST = emgsd_pkg::PIPE_DEPTH - 1;
  localparam logic [52:0] R8 = 53'(emgsd_pkg::R8_Q32);
  localparam logic        R8B0 = emgsd_pkg::R8_Q32[0];

  // configuration registers
  logic [31:0] mean_position;
  logic [30:0] spread;
  logic [31:0] decay_rate;
  logic [16:0] strand_bias;
  logic [30:0] footprint_offset;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_position    <= 32'd0;
      spread           <= 31'd65536;
      decay_rate       <= 32'd268435456;
      strand_bias      <= 17'd32768;
      footprint_offset <= 31'd2621440;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        emgsd_pkg::REG_MEAN_POSITION:    mean_position    <= cfg.data;
        emgsd_pkg::REG_SPREAD:           spread           <= cfg.data[30:0];
        emgsd_pkg::REG_DECAY_RATE:       decay_rate       <= cfg.data;
        emgsd_pkg::REG_STRAND_BIAS:      strand_bias      <= cfg.data[16:0];
        emgsd_pkg::REG_FOOTPRINT_OFFSET: footprint_offset <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // pipeline control: every stage moves unless the output word is held
  logic [LAST:0] vld;
  logic          en;

  assign en          = !vld[LAST] || result.ready;
  assign reads.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], reads.valid};
    end
  end

  // stage 1: footprint shift and strand-signed distance
  logic [34:0] z_x, mu_x, fo_x, zs_c, d_c, dm_c;
  logic        f_plus, f_szero, f_dneg;
  logic [32:0] f_dmag;

  always_comb begin
    z_x  = {{3{reads.position[31]}}, reads.position};
    mu_x = {{3{mean_position[31]}}, mean_position};
    fo_x = {4'b0, footprint_offset};
    zs_c = reads.strand_plus ? z_x - fo_x : z_x + fo_x;
    d_c  = reads.strand_plus ? mu_x - zs_c : zs_c - mu_x;
    dm_c = d_c[34] ? -d_c : d_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_plus  <= reads.strand_plus;
      f_szero <= (spread == '0);
      f_dneg  <= d_c[34];
      f_dmag  <= dm_c[32:0];
    end
  end

  // stage 2: saturation test, lambda*sigma, divider seed
  emgsd_pkg::wc_t w_ctl [0:40];
  logic [30:0]    w_rem [0:40];
  logic [39:0]    w_q   [0:40];
  logic [62:0]    ls_prod;

  assign ls_prod = 63'(decay_rate) * 63'(spread);

  always_ff @(posedge clk) begin
    if (en) begin
      w_ctl[0].plus  <= f_plus;
      w_ctl[0].szero <= f_szero;
      w_ctl[0].dneg  <= f_dneg;
      w_ctl[0].sat   <= {6'b0, f_dmag} >= {spread, 8'b0};
      w_ctl[0].dmag  <= f_dmag;
      w_ctl[0].ls    <= ls_prod[62:12];
      w_rem[0]       <= {6'b0, f_dmag[32:8]};
      w_q[0]         <= '0;
    end
  end

  // |d|/sigma in Q32, one quotient bit a stage
  for (genvar j = 0; j < emgsd_pkg::WDIV_STG; j++) begin : g_wdiv
    logic        nb;
    logic [31:0] r2;
    logic        ge;
    if (j < 8) begin : g_bit
      assign nb = w_ctl[j].dmag[7-j];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign r2 = {w_rem[j], nb};
    assign ge = r2 >= {1'b0, spread};
    always_ff @(posedge clk) begin
      if (en) begin
        w_ctl[j+1] <= w_ctl[j];
        w_rem[j+1] <= ge ? 31'(r2 - {1'b0, spread}) : r2[30:0];
        w_q[j+1]   <= {w_q[j][38:0], ge};
      end
    end
  end

  // v1: v = s*w + lambda*sigma, and the squares and products for u and A
  emgsd_pkg::wc_t wc;
  emgsd_pkg::v1_t v1;
  logic [40:0]    wmag;
  logic [52:0]    wext, lsext;

  always_comb begin
    wc    = w_ctl[40];
    wmag  = wc.sat ? (41'd1 << 40) : {1'b0, w_q[40]};
    wext  = {12'b0, wmag};
    lsext = {2'b0, wc.ls};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1.plus  <= wc.plus;
      v1.szero <= wc.szero;
      v1.big   <= |wmag[40:36];
      v1.lsbig <= |wc.ls[50:36];
      v1.v     <= (wc.dneg ? -wext : wext) + lsext;
      v1.whsq  <= 56'(wmag[35:8]) * 56'(wmag[35:8]);
      v1.ldh   <= 49'(decay_rate) * 49'(wc.dmag[32:16]);
      v1.ldl   <= 48'(decay_rate) * 48'(wc.dmag[15:0]);
      v1.lsq   <= 56'(wc.ls[35:8]) * 56'(wc.ls[35:8]);
    end
  end

  // v2: |v|, u = w^2/2, exponent for the lambda*exp(A) term, tau divisor
  emgsd_pkg::tc_t t_ctl [0:29];
  logic [52:0]    t_rem [0:29];
  logic [52:0]    t_d   [0:29];
  logic [28:0]    t_q   [0:29];
  logic           vneg;
  logic [52:0]    vabs;
  logic [53:0]    ld, sq, nega;
  logic [49:0]    n4;

  always_comb begin
    vneg = v1.v[52];
    vabs = vneg ? -v1.v : v1.v;
    ld   = {1'b0, v1.ldh, 4'b0} + 54'(v1.ldl[47:12]);
    sq   = 54'(v1.lsq[55:17]);
    nega = (ld > sq) ? ld - sq : '0;
    n4   = nega[53:4];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_ctl[0].plus  <= v1.plus;
      t_ctl[0].szero <= v1.szero;
      t_ctl[0].vneg  <= vneg;
      t_ctl[0].lsbig <= v1.lsbig;
      t_ctl[0].u28   <= v1.big ? emgsd_pkg::EXP_CAP : 36'(v1.whsq[55:21]);
      t_ctl[0].m1    <= (n4 > 50'(emgsd_pkg::EXP_CAP)) ? emgsd_pkg::EXP_CAP : n4[35:0];
      t_d[0]         <= R8 + vabs;
      t_rem[0]       <= R8 >> 1;
      t_q[0]         <= '0;
    end
  end

  // tau = 2sqrt2 / (2sqrt2 + |v|) in Q28, one quotient bit a stage
  for (genvar j = 0; j < emgsd_pkg::TDIV_STG; j++) begin : g_tdiv
    logic        nb;
    logic [53:0] r2;
    logic        ge;
    assign nb = (j == 0) ? R8B0 : 1'b0;
    assign r2 = {t_rem[j], nb};
    assign ge = r2 >= {1'b0, t_d[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        t_ctl[j+1] <= t_ctl[j];
        t_d[j+1]   <= t_d[j];
        t_rem[j+1] <= ge ? 53'(r2 - {1'b0, t_d[j]}) : r2[52:0];
        t_q[j+1]   <= {t_q[j][27:0], ge};
      end
    end
  end

  // erfc polynomial by horner steps, multiply stage then add stage
  emgsd_pkg::hc_t hc [0:9];
  logic [33:0]    hp [0:9];
  emgsd_pkg::hc_t ha_c    [0:8];
  logic [62:0]    ha_prod [0:8];
  logic           ha_neg  [0:8];

  assign hc[0].t   = t_ctl[29];
  assign hc[0].tau = t_q[29];
  assign hp[0]     = emgsd_pkg::POLY[9];

  for (genvar k = 0; k < 9; k++) begin : g_horn
    logic [33:0] mag, r, sr;
    assign mag = hp[k][33] ? -hp[k] : hp[k];
    assign r   = ha_prod[k][61:28];
    assign sr  = ha_neg[k] ? -r : r;
    always_ff @(posedge clk) begin
      if (en) begin
        ha_prod[k] <= 63'(mag) * 63'(hc[k].tau);
        ha_neg[k]  <= hp[k][33];
        ha_c[k]    <= hc[k];
        hp[k+1]    <= emgsd_pkg::POLY[8-k] + sr;
        hc[k+1]    <= ha_c[k];
      end
    end
  end

  // exponent P - u (clamped at 0 above) and lambda*tau
  emgsd_pkg::xc_t xc [0:45];
  logic [35:0]    m_a, m_b;
  logic [33:0]    p_neg;
  logic [36:0]    m_c;
  logic [60:0]    lt_prod;

  always_comb begin
    p_neg   = -hp[9];
    m_c     = (hp[9][33] ? 37'(p_neg) : 37'd0) + 37'(hc[9].t.u28);
    lt_prod = 61'(decay_rate) * 61'(hc[9].tau);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_a         <= (m_c > 37'(emgsd_pkg::EXP_CAP)) ? emgsd_pkg::EXP_CAP : m_c[35:0];
      m_b         <= hc[9].t.m1;
      xc[0].plus  <= hc[9].t.plus;
      xc[0].szero <= hc[9].t.szero;
      xc[0].vneg  <= hc[9].t.vneg;
      xc[0].lsbig <= hc[9].t.lsbig;
      xc[0].lt    <= lt_prod[60:28];
    end
  end

  // two exp units: tail term and the lambda*exp(A) term
  logic [30:0] ea, eb;

  emgsd_exp u_exp_tail (
    .clk (clk),
    .en  (en),
    .m   (m_a),
    .e   (ea)
  );

  emgsd_exp u_exp_lead (
    .clk (clk),
    .en  (en),
    .m   (m_b),
    .e   (eb)
  );

  for (genvar j = 0; j < emgsd_pkg::EXP_LAT; j++) begin : g_xdly
    always_ff @(posedge clk) begin
      if (en) begin
        xc[j+1] <= xc[j];
      end
    end
  end

  // term products
  logic [63:0] t2_prod;
  logic [62:0] t1_prod;
  logic [28:0] p_t1, p_t2;
  logic        p_plus, p_szero, p_vneg, p_lsbig;

  assign t2_prod = 64'(xc[45].lt) * 64'(ea);
  assign t1_prod = 63'(decay_rate) * 63'(eb);

  always_ff @(posedge clk) begin
    if (en) begin
      p_t2    <= t2_prod[63:35];
      p_t1    <= t1_prod[62:34];
      p_plus  <= xc[45].plus;
      p_szero <= xc[45].szero;
      p_vneg  <= xc[45].vneg;
      p_lsbig <= xc[45].lsbig;
    end
  end

  // combine terms, strand weight
  logic [28:0] f_c;
  logic [16:0] pi_c;
  logic [28:0] q_f;
  logic [16:0] q_w;
  logic        q_szero;

  always_comb begin
    if (!p_vneg) begin
      f_c = p_t2;
    end else if (p_lsbig) begin
      f_c = '0;
    end else begin
      f_c = (p_t1 > p_t2) ? p_t1 - p_t2 : '0;
    end
    pi_c = (strand_bias > 17'd65536) ? 17'd65536 : strand_bias;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_f     <= f_c;
      q_w     <= p_plus ? pi_c : 17'd65536 - pi_c;
      q_szero <= p_szero;
    end
  end

  // output word; f stays below 2^28 so the weighted value always fits 32 bits
  logic [45:0] dens_prod;
  logic [31:0] o_density;
  logic        o_forced;

  assign dens_prod = 46'(q_f) * 46'(q_w);

  always_ff @(posedge clk) begin
    if (en) begin
      o_density <= q_szero ? '0 : {2'b0, dens_prod[45:16]};
      o_forced  <= q_szero;
    end
  end

  assign result.valid       = vld[LAST];
  assign result.density     = o_density;
  assign result.forced_zero = o_forced;

  // checks
  a_forced_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.forced_zero |-> result.density == 32'd0)
    else $error("forced word carries a nonzero density");

  a_density_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.density[31:28] == 4'd0)
    else $error("density above the bound of the formula");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    reads.valid && reads.ready |=> vld[0])
    else $error("accepted read did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> $stable(vld) && $stable(o_density))
    else $error("pipeline moved while the output word was held");

endmodule

/* rtl/emgsd_exp.sv */
// emgsd_exp: pipelined exp(-m), m in Q28 capped at 128, result in Q30
// depends on emgsd_pkg
`timescale 1ns / 1ps

module emgsd_exp (
  input  logic        clk,
  input  logic        en,
  input  logic [35:0] m,
  output logic [30:0] e
);

  localparam logic [27:0] LN = 28'(emgsd_pkg::LN2_Q28);

  // range reduction m = k*ln2 + r, one quotient bit a stage
  logic [35:0] kr [0:8];
  logic [7:0]  kk [0:8];

  assign kr[0] = m;
  assign kk[0] = '0;

  for (genvar j = 0; j < 8; j++) begin : g_red
    localparam logic [35:0] THR = 36'(LN) << (7 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        if (kr[j] >= THR) begin
          kr[j+1] <= kr[j] - THR;
          kk[j+1] <= {kk[j][6:0], 1'b1};
        end else begin
          kr[j+1] <= kr[j];
          kk[j+1] <= {kk[j][6:0], 1'b0};
        end
      end
    end
  end

  // series acc = 1 - g*acc/i, i from 12 down to 1, three stages a term
  logic [30:0] sa_acc [0:12];
  logic [29:0] sa_g   [0:12];
  logic [7:0]  sa_k   [0:12];
  logic [60:0] pa_prod [0:11];
  logic [29:0] pa_g    [0:11];
  logic [7:0]  pa_k    [0:11];
  logic [30:0] pb_x    [0:11];
  logic [30:0] pb_q0   [0:11];
  logic [29:0] pb_g    [0:11];
  logic [7:0]  pb_k    [0:11];

  assign sa_acc[0] = emgsd_pkg::ONE30;
  assign sa_g[0]   = {kr[8][27:0], 2'b00};
  assign sa_k[0]   = kk[8];

  for (genvar s = 0; s < 12; s++) begin : g_term
    localparam int unsigned DV = 12 - s;
    localparam logic [34:0] RCP = 35'((64'd1 << 34) / DV);
    logic [65:0] xr;
    logic [34:0] rem;
    logic [30:0] q;

    always_comb begin
      xr  = 66'(pa_prod[s][60:30]) * 66'(RCP);
      rem = 35'(pb_x[s]) - 35'(pb_q0[s]) * 35'(DV);
      q   = (rem >= 35'(DV)) ? pb_q0[s] + 31'd1 : pb_q0[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa_prod[s] <= 61'(sa_g[s]) * 61'(sa_acc[s]);
        pa_g[s]    <= sa_g[s];
        pa_k[s]    <= sa_k[s];
        pb_x[s]    <= pa_prod[s][60:30];
        pb_q0[s]   <= xr[64:34];
        pb_g[s]    <= pa_g[s];
        pb_k[s]    <= pa_k[s];
        sa_acc[s+1] <= emgsd_pkg::ONE30 - q;
        sa_g[s+1]  <= pb_g[s];
        sa_k[s+1]  <= pb_k[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e <= (sa_k[12] >= 8'd31) ? '0 : (sa_acc[12] >> sa_k[12]);
    end
  end

endmodule
